[hw/rtl/qhp_pkg.sv]
`timescale 1ns / 1ps

package qhp_pkg;

	localparam int MAX_CID_BYTES = 8;

	localparam logic [2:0] KIND_ZERO_RTT = 3'd1;
	localparam logic [2:0] KIND_VERNEG   = 3'd4;
	localparam logic [2:0] KIND_SHORT    = 3'd5;

	localparam logic REG_SERVER_ROLE    = 1'b0;
	localparam logic REG_CONN_ID_LENGTH = 1'b1;

	// Snapshot of one packet, taken as its last byte is accepted.
	typedef struct packed {
		logic        server_role;
		logic [3:0]  conn_id_length;
		logic        form;
		logic        version_zero;
		logic [7:0]  lead_byte;
		logic [7:0]  cid_len_byte;
		logic [63:0] cid;
		logic [31:0] pn;
		logic        n_over;
		logic [5:0]  n_sat;
		logic [1:0]  n_lo;
		logic [11:0] size;
	} qhp_rec_t;

	typedef struct packed {
		logic        parse_error;
		logic [2:0]  header_kind;
		logic [1:0]  pn_len_code;
		logic [31:0] packet_number;
		logic [63:0] conn_id;
		logic        conn_id_present;
		logic [11:0] version_info;
		logic [11:0] nonce_offset;
		logic [11:0] header_size;
		logic [11:0] packet_size;
	} qhp_res_t;

	function automatic logic [4:0] nib_len(input logic [3:0] n);
		return (n == 4'd0) ? 5'd0 : ({1'b0, n} + 5'd3);
	endfunction

endpackage

[hw/rtl/qhp_fifo.sv]
`timescale 1ns / 1ps

module qhp_fifo import qhp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_en,
	input  qhp_rec_t wr_data,
	output logic     full,
	input  logic     rd_en,
	output qhp_rec_t rd_data,
	output logic     empty
);

	qhp_rec_t   entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_wr;
	logic       do_rd;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= ~wr_ptr_q;
			if (do_rd) rd_ptr_q <= ~rd_ptr_q;
			if (do_wr && !do_rd) count_q <= count_q + 2'd1;
			else if (do_rd && !do_wr) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) entry_q[wr_ptr_q] <= wr_data;
	end

endmodule

[hw/rtl/qhp_front.sv]
`timescale 1ns / 1ps

module qhp_front import qhp_pkg::*; #(
	parameter int MAX_PACKET_BYTES = 2048
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       func,
	input  logic [7:0] data_byte,
	input  logic       start_of_packet,
	input  logic       end_of_packet,
	input  logic       server_role,
	input  logic [3:0] conn_id_length,
	output logic       rec_push,
	output qhp_rec_t   rec,
	input  logic       rec_full
);

	localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 2);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PACKET_BYTES);

	logic [CNT_W-1:0] count_q;
	logic             form_q;
	logic [7:0]       lead_q;
	logic             vz_q;
	logic [7:0]       cidlen_q;
	logic [63:0]      cid_q;
	logic [31:0]      pn_q;

	logic             accept;
	logic [CNT_W-1:0] o;
	logic             first;
	logic             form;
	logic [7:0]       lead;
	logic             vz_next;
	logic [7:0]       cidlen_next;
	logic [63:0]      cid_base;
	logic [63:0]      cid_next;
	logic [31:0]      pn_base;
	logic [31:0]      pn_next;
	logic [2:0]       plen;
	logic [4:0]       cid_lo;
	logic [4:0]       pn_lo;
	logic [5:0]       pn_hi;
	logic             in_cid;
	logic             in_pn;
	logic [CNT_W-1:0] n;
	logic             n_over;

	assign full     = rec_full;
	assign accept   = push && !rec_full;
	assign rec_push = accept && end_of_packet;

	always_comb begin
		o           = start_of_packet ? '0 : count_q;
		first       = (o == '0);
		form        = first ? func : form_q;
		lead        = first ? data_byte : lead_q;
		cid_base    = first ? 64'd0 : cid_q;
		pn_base     = first ? 32'd0 : pn_q;
		plen        = {1'b0, lead[1:0]} + 3'd1;
		vz_next     = (first ? 1'b1 : vz_q) &
			~(form && o >= CNT_W'(1) && o <= CNT_W'(4) && data_byte != 8'd0);
		cidlen_next = (form && o == CNT_W'(5)) ? data_byte : (first ? 8'd0 : cidlen_q);
		cid_lo      = form ? 5'd6 : 5'd1;
		pn_lo       = cid_lo + ((form || server_role) ? {1'b0, conn_id_length} : 5'd0);
		pn_hi       = {1'b0, pn_lo} + {3'b0, plen};
		in_cid      = (o >= CNT_W'(cid_lo)) && (o < CNT_W'(pn_lo));
		in_pn       = (o >= CNT_W'(pn_lo)) && (o < CNT_W'(pn_hi));
		cid_next    = in_cid ? {cid_base[55:0], data_byte} : cid_base;
		pn_next     = in_pn ? {pn_base[23:0], data_byte} : pn_base;
		n           = (o <= MAX_CNT) ? o + CNT_W'(1) : o;
		n_over      = (n > MAX_CNT);

		rec.server_role    = server_role;
		rec.conn_id_length = conn_id_length;
		rec.form           = form;
		rec.version_zero   = vz_next;
		rec.lead_byte      = lead;
		rec.cid_len_byte   = cidlen_next;
		rec.cid            = cid_next;
		rec.pn             = pn_next;
		rec.n_over         = n_over;
		rec.n_sat          = (n > CNT_W'(63)) ? 6'd63 : n[5:0];
		rec.n_lo           = n[1:0];
		rec.size           = 12'(n_over ? MAX_CNT : n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			form_q   <= 1'b0;
			lead_q   <= 8'd0;
			vz_q     <= 1'b1;
			cidlen_q <= 8'd0;
			cid_q    <= 64'd0;
			pn_q     <= 32'd0;
		end else if (accept) begin
			count_q  <= end_of_packet ? '0 : n;
			form_q   <= form;
			lead_q   <= lead;
			vz_q     <= vz_next;
			cidlen_q <= cidlen_next;
			cid_q    <= cid_next;
			pn_q     <= pn_next;
		end
	end

endmodule

[hw/rtl/qhp_back.sv]
`timescale 1ns / 1ps

module qhp_back import qhp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  qhp_rec_t rec,
	input  logic     rec_valid,
	output logic     rec_pop,
	output qhp_res_t res,
	output logic     res_valid,
	input  logic     res_pop
);

	qhp_res_t   res_q;
	logic       valid_q;
	qhp_res_t   nxt;
	logic [3:0] cl;
	logic [2:0] plen;
	logic [4:0] dcil;
	logic [4:0] scil;
	logic       verneg;
	logic       role_bad;
	logic [5:0] need;
	logic [5:0] n6;
	logic [4:0] p;
	logic       vn_bad;
	logic       err_long;
	logic [4:0] hdr_short;
	logic       err_short;
	logic       err;
	logic [5:0] hdr_long;
	logic [2:0] kind_long;

	assign rec_pop   = rec_valid && (!valid_q || res_pop);
	assign res       = res_q;
	assign res_valid = valid_q;

	always_comb begin
		cl        = rec.conn_id_length;
		plen      = {1'b0, rec.lead_byte[1:0]} + 3'd1;
		dcil      = nib_len(rec.cid_len_byte[7:4]);
		scil      = nib_len(rec.cid_len_byte[3:0]);
		verneg    = rec.version_zero;
		role_bad  = rec.server_role ? !(dcil == {1'b0, cl} && scil == 5'd0)
			: !(dcil == 5'd0 && scil == {1'b0, cl});
		need      = {1'b0, dcil} + {1'b0, scil} + (verneg ? 6'd4 : {3'b0, plen});
		n6        = rec.n_sat - 6'd6;
		p         = 5'd6 + {1'b0, cl};
		vn_bad    = ({1'b0, p} >= rec.n_sat) || ((rec.n_lo - p[1:0]) != 2'd0);
		err_long  = (rec.n_sat < 6'd6) || role_bad || (n6 < need) || (verneg && vn_bad);
		hdr_short = 5'd1 + (rec.server_role ? {1'b0, cl} : 5'd0) + {2'b0, plen};
		err_short = !rec.lead_byte[6] || (rec.n_sat < {1'b0, hdr_short});
		err       = rec.n_over || (cl > 4'(MAX_CID_BYTES)) || (rec.form ? err_long : err_short);
		kind_long = {1'b0, rec.lead_byte[5:4]};
		hdr_long  = {1'b0, p} + {3'b0, plen};

		nxt             = '0;
		nxt.packet_size = rec.size;
		if (err) begin
			nxt.parse_error = 1'b1;
		end else if (rec.form) begin
			nxt.conn_id         = rec.cid;
			nxt.conn_id_present = 1'b1;
			if (verneg) begin
				nxt.header_kind  = KIND_VERNEG;
				nxt.version_info = {7'd0, p};
				nxt.header_size  = rec.size;
			end else begin
				nxt.header_kind   = kind_long;
				nxt.pn_len_code   = rec.lead_byte[1:0];
				nxt.packet_number = rec.pn;
				nxt.version_info  = 12'd1;
				nxt.header_size   = {6'd0, hdr_long};
				if (!rec.server_role && kind_long == KIND_ZERO_RTT) begin
					nxt.nonce_offset = {6'd0, hdr_long};
					nxt.header_size  = {6'd0, hdr_long} + 12'd32;
				end
			end
		end else begin
			nxt.header_kind     = KIND_SHORT;
			nxt.pn_len_code     = rec.lead_byte[1:0];
			nxt.packet_number   = rec.pn;
			nxt.header_size     = {7'd0, hdr_short};
			nxt.conn_id_present = rec.server_role;
			nxt.conn_id         = rec.server_role ? rec.cid : 64'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rec_pop) begin
			valid_q <= 1'b1;
		end else if (res_pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_pop) res_q <= nxt;
	end

endmodule

[hw/rtl/quic_q046_header_parser.sv]
`timescale 1ns / 1ps
// Channel   Handshake        Payload
// bytes     push / full      func, data_byte, start_of_packet, end_of_packet
// results   empty / pop      parse_error .. packet_size, one per packet
// config    write_en         reg_index, write_data
//
// One byte is taken every cycle while full is low.
// A result reaches the output once its packet's record has passed through a queue entry and the
// output register, unless earlier results are still waiting.
// A two-entry queue sits between the byte front end and the result stage; full rises
// only when both entries and the output register hold results nobody has popped.
// Reset clears the byte count, the queue and the output register, and sets
// server_role to 0 and conn_id_length to 8.

module quic_q046_header_parser import qhp_pkg::*; #(
	parameter int MAX_PACKET_BYTES = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        func,
	input  logic [7:0]  data_byte,
	input  logic        start_of_packet,
	input  logic        end_of_packet,
	output logic        empty,
	input  logic        pop,
	output logic        parse_error,
	output logic [2:0]  header_kind,
	output logic [1:0]  pn_len_code,
	output logic [31:0] packet_number,
	output logic [63:0] conn_id,
	output logic        conn_id_present,
	output logic [11:0] version_info,
	output logic [11:0] nonce_offset,
	output logic [11:0] header_size,
	output logic [11:0] packet_size,
	input  logic        write_en,
	input  logic        reg_index,
	input  logic [3:0]  write_data
);

	logic       server_role_q;
	logic [3:0] conn_id_length_q;
	qhp_rec_t   rec_in;
	qhp_rec_t   rec_out;
	logic       rec_push;
	logic       rec_full;
	logic       rec_empty;
	logic       rec_pop;
	qhp_res_t   res;
	logic       res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_role_q    <= 1'b0;
			conn_id_length_q <= 4'd8;
		end else if (write_en) begin
			case (reg_index)
				REG_SERVER_ROLE:    server_role_q <= write_data[0];
				REG_CONN_ID_LENGTH: conn_id_length_q <= write_data;
				default: ;
			endcase
		end
	end

	qhp_front #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.func           (func),
		.data_byte      (data_byte),
		.start_of_packet(start_of_packet),
		.end_of_packet  (end_of_packet),
		.server_role    (server_role_q),
		.conn_id_length (conn_id_length_q),
		.rec_push       (rec_push),
		.rec            (rec_in),
		.rec_full       (rec_full)
	);

	qhp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (rec_push),
		.wr_data(rec_in),
		.full   (rec_full),
		.rd_en  (rec_pop),
		.rd_data(rec_out),
		.empty  (rec_empty)
	);

	qhp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rec      (rec_out),
		.rec_valid(!rec_empty),
		.rec_pop  (rec_pop),
		.res      (res),
		.res_valid(res_valid),
		.res_pop  (pop)
	);

	assign empty           = !res_valid;
	assign parse_error     = res.parse_error;
	assign header_kind     = res.header_kind;
	assign pn_len_code     = res.pn_len_code;
	assign packet_number   = res.packet_number;
	assign conn_id         = res.conn_id;
	assign conn_id_present = res.conn_id_present;
	assign version_info    = res.version_info;
	assign nonce_offset    = res.nonce_offset;
	assign header_size     = res.header_size;
	assign packet_size     = res.packet_size;

endmodule

[hw/rtl/qhp_checker.sv]
`timescale 1ns / 1ps

module qhp_checker import qhp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic        parse_error,
	input logic [2:0]  header_kind,
	input logic [1:0]  pn_len_code,
	input logic [31:0] packet_number,
	input logic [63:0] conn_id,
	input logic        conn_id_present,
	input logic [11:0] version_info,
	input logic [11:0] nonce_offset,
	input logic [11:0] header_size,
	input logic [11:0] packet_size
);

	// A rejected header carries nothing but its size.
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && parse_error) |-> (header_kind == 3'd0 && packet_number == 32'd0 &&
			conn_id == 64'd0 && !conn_id_present && header_size == 12'd0 &&
			nonce_offset == 12'd0 && version_info == 12'd0))
		else $error("rejected header carries field data");

	// Version negotiation has no packet number.
	a_verneg_no_pn: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !parse_error && header_kind == KIND_VERNEG) |->
			(pn_len_code == 2'd0 && packet_number == 32'd0 && conn_id_present))
		else $error("version negotiation result carries a packet number");

	// A nonce appears only in zero-rtt and extends the header by 32 bytes.
	a_nonce_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !parse_error && nonce_offset != 12'd0) |->
			(header_kind == KIND_ZERO_RTT && header_size == nonce_offset + 12'd32))
		else $error("nonce offset inconsistent with header size");

	// Short headers have neither version nor nonce.
	a_short_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !parse_error && header_kind == KIND_SHORT) |->
			(version_info == 12'd0 && nonce_offset == 12'd0))
		else $error("short header carries version or nonce");

	// A waiting result stays put until popped.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(packet_size) && $stable(header_size)))
		else $error("waiting result changed before pop");

endmodule

bind quic_q046_header_parser qhp_checker u_qhp_checker (.*);
